/* hdl/tpag_pkg.sv */
// Shared types, constants and field helpers for the tensor permute address generator.
// No dependencies; imported by every module of the block.
package tpag_pkg;

  localparam int PACKED_DIMS     = 4;   // dimensions packed into the config registers
  localparam int SIZE_W          = 16;
  localparam int STRIDE_W        = 32;
  localparam int PERM_W          = 2;
  localparam int CNT_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int OUT_W           = 32;
  localparam int MAX_DIMS_DEF    = 4;
  localparam int OFFSET_BITS_DEF = 32;

  typedef logic [SIZE_W-1:0]     coord_t;
  typedef logic [STRIDE_W-1:0]   stride_t;
  typedef logic [PERM_W-1:0]     dim_idx_t;
  typedef logic [CNT_W-1:0]      dim_cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  // Register indexes on the config port
  localparam cfg_idx_t REG_DIM_COUNT  = 3'd0;
  localparam cfg_idx_t REG_DIM_SIZES  = 3'd1;
  localparam cfg_idx_t REG_PERM_MAP   = 3'd2;
  localparam cfg_idx_t REG_SRC_LOW    = 3'd3;
  localparam cfg_idx_t REG_SRC_HIGH   = 3'd4;
  localparam cfg_idx_t REG_DST_LOW    = 3'd5;
  localparam cfg_idx_t REG_DST_HIGH   = 3'd6;

  // Config register file as seen by the datapath
  typedef struct packed {
    dim_cnt_t   dim_count;
    cfg_word_t  dim_sizes;
    logic [7:0] perm_map;
    cfg_word_t  src_low;
    cfg_word_t  src_high;
    cfg_word_t  dst_low;
    cfg_word_t  dst_high;
  } cfg_regs_t;

  // Size of dimension d; a zero size counts as one
  function automatic coord_t size_of(cfg_word_t sizes, dim_idx_t d);
    coord_t s;
    s = sizes[d*SIZE_W +: SIZE_W];
    return (s == '0) ? coord_t'(1) : s;
  endfunction

  // 32-bit stride of dimension d from a low/high register pair
  function automatic stride_t stride_of(cfg_word_t lo, cfg_word_t hi, dim_idx_t d);
    cfg_word_t w;
    w = d[1] ? hi : lo;
    return d[0] ? w[2*STRIDE_W-1:STRIDE_W] : w[STRIDE_W-1:0];
  endfunction

  // Source dimension feeding destination dimension d
  function automatic dim_idx_t perm_of(logic [7:0] pm, dim_idx_t d);
    return pm[d*PERM_W +: PERM_W];
  endfunction

  // Dimensions in use: zero counts as one, clamped to the lane count
  function automatic dim_cnt_t active_dims(dim_cnt_t cnt, dim_cnt_t limit);
    dim_cnt_t n;
    n = cnt;
    if (n == '0) n = dim_cnt_t'(1);
    if (n > limit) n = limit;
    return n;
  endfunction

endpackage

/* hdl/tpag_stride_derive.sv */
// Destination stride resolution: zero strides become dense strides.
// Depends on tpag_pkg. One registered 32x16 multiply per dimension above dimension 0.
module tpag_stride_derive #(
  parameter int NDIM = tpag_pkg::PACKED_DIMS
) (
  input  logic                clk,
  input  tpag_pkg::cfg_regs_t cfg,
  output tpag_pkg::stride_t   dstr [NDIM]
);
  import tpag_pkg::*;

  stride_t raw0;
  stride_t elem;

  // Dimension 0: element size when dense
  assign raw0    = stride_of(cfg.dst_low, cfg.dst_high, dim_idx_t'(0));
  assign elem    = stride_of(cfg.src_low, cfg.src_high, dim_idx_t'(0));
  assign dstr[0] = (raw0 == '0) ? elem : raw0;

  // Higher dimensions: previous stride times previous permuted size, one stage each
  for (genvar d = 1; d < NDIM; d++) begin : g_dense
    stride_t raw;
    stride_t prod;
    coord_t  psize;
    assign raw   = stride_of(cfg.dst_low, cfg.dst_high, dim_idx_t'(d));
    assign psize = size_of(cfg.dim_sizes, perm_of(cfg.perm_map, dim_idx_t'(d - 1)));
    assign prod  = STRIDE_W'(dstr[d-1] * stride_t'(psize));
    always_ff @(posedge clk) begin
      dstr[d] <= (raw == '0) ? prod : raw;
    end
  end

endmodule

/* hdl/tpag_odometer.sv */
// Source coordinate counter (dimension 0 fastest) and the stage-1 snapshot register.
// Depends on tpag_pkg.
module tpag_odometer #(
  parameter int NDIM = tpag_pkg::PACKED_DIMS
) (
  input  logic                clk,
  input  logic                rst,
  input  tpag_pkg::cfg_regs_t cfg,
  input  logic                advance,
  input  logic                restart,
  output tpag_pkg::coord_t    snap [tpag_pkg::PACKED_DIMS],
  output logic                snap_last
);
  import tpag_pkg::*;

  localparam dim_cnt_t LIMIT = dim_cnt_t'(NDIM);

  coord_t   coord      [NDIM];
  coord_t   coord_next [NDIM];
  coord_t   work       [PACKED_DIMS];
  dim_cnt_t n;
  logic     wrap;

  assign n = active_dims(cfg.dim_count, LIMIT);

  // Working coordinate: cleared on restart, unused dimensions held at zero
  for (genvar d = 0; d < PACKED_DIMS; d++) begin : g_work
    if (d < NDIM) begin : g_lane
      assign work[d] = (!restart && (d < int'(n))) ? coord[d] : '0;
    end else begin : g_pad
      assign work[d] = '0;
    end
  end

  // Increment with carry ripple; a carry out of the top wraps the whole coordinate
  always_comb begin
    logic        carry;
    logic [16:0] c;
    carry = 1'b1;
    c     = '0;
    for (int d = 0; d < NDIM; d++) begin
      coord_next[d] = '0;
      if (d < int'(n)) begin
        if (carry) begin
          c = {1'b0, work[d]} + 17'd1;
          if (c >= {1'b0, size_of(cfg.dim_sizes, dim_idx_t'(d))}) begin
            coord_next[d] = '0;
          end else begin
            coord_next[d] = c[SIZE_W-1:0];
            carry         = 1'b0;
          end
        end else begin
          coord_next[d] = work[d];
        end
      end
    end
    wrap = carry;
  end

  // Coordinate state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NDIM; d++) coord[d] <= '0;
    end else if (advance) begin
      for (int d = 0; d < NDIM; d++) coord[d] <= coord_next[d];
    end
  end

  // Snapshot of the coordinate this item addresses
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int d = 0; d < PACKED_DIMS; d++) snap[d] <= work[d];
      snap_last <= wrap;
    end
  end

endmodule

/* hdl/tpag_offset_calc.sv */
// Source and destination dot products feeding the result register.
// Depends on tpag_pkg.
module tpag_offset_calc #(
  parameter int NDIM        = tpag_pkg::PACKED_DIMS,
  parameter int OFFSET_BITS = tpag_pkg::OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    load,
  input  tpag_pkg::cfg_regs_t     cfg,
  input  tpag_pkg::stride_t       dstr [NDIM],
  input  tpag_pkg::coord_t        snap [tpag_pkg::PACKED_DIMS],
  input  logic                    snap_last,
  output logic [tpag_pkg::OUT_W-1:0] src_offset,
  output logic [tpag_pkg::OUT_W-1:0] dst_offset,
  output logic [tpag_pkg::OUT_W-1:0] element_bytes,
  output logic                    last
);
  import tpag_pkg::*;

  localparam dim_cnt_t LIMIT  = dim_cnt_t'(NDIM);
  localparam int       PROD_W = SIZE_W + STRIDE_W;

  dim_cnt_t               n;
  logic [OFFSET_BITS-1:0] so;
  logic [OFFSET_BITS-1:0] dof;

  assign n = active_dims(cfg.dim_count, LIMIT);

  // Dot products over active dimensions, modulo 2^OFFSET_BITS
  always_comb begin
    logic [PROD_W-1:0] ps;
    logic [PROD_W-1:0] pd;
    so  = '0;
    dof = '0;
    for (int d = 0; d < NDIM; d++) begin
      ps = PROD_W'(snap[d]) *
           PROD_W'(stride_of(cfg.src_low, cfg.src_high, dim_idx_t'(d)));
      pd = PROD_W'(snap[perm_of(cfg.perm_map, dim_idx_t'(d))]) * PROD_W'(dstr[d]);
      if (d < int'(n)) begin
        so  = so  + OFFSET_BITS'(ps);
        dof = dof + OFFSET_BITS'(pd);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      src_offset    <= OUT_W'(so);
      dst_offset    <= OUT_W'(dof);
      element_bytes <= stride_of(cfg.src_low, cfg.src_high, dim_idx_t'(0));
      last          <= snap_last;
    end
  end

endmodule

/* hdl/tensor_permute_address_gen.sv */
// Tensor permute address generator: one source/destination offset pair per item.
// Items pass the snapshot register and result register; throughput 1 item per cycle
// unless m_tready back-pressure or stride settling stalls it. Dense destination strides
// resolve through a chain of registered multipliers, so s_tready stays low after reset
// and after each config write until the chain settles. Reset (rst, synchronous) loads
// register defaults and zeroes the coordinate. Depends on tpag_pkg and tpag_* modules.
module tensor_permute_address_gen #(
  parameter int MAX_DIMS    = tpag_pkg::MAX_DIMS_DEF,
  parameter int OFFSET_BITS = tpag_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  tpag_pkg::cfg_idx_t            cfg_index,
  input  tpag_pkg::cfg_word_t           cfg_data,
  // Input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] restart, [7:1] zero
  // Result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [3*tpag_pkg::OUT_W-1:0]  m_tdata,   // [31:0] src_offset, [63:32] dst_offset,
                                                   // [95:64] element_bytes
  output logic                          m_tlast    // last element of the tensor
);
  import tpag_pkg::*;

  localparam int NDIM     = (MAX_DIMS < PACKED_DIMS) ? MAX_DIMS : PACKED_DIMS;
  localparam int SETTLE_W = $clog2(NDIM + 1);

  cfg_regs_t           cfg;
  logic [SETTLE_W-1:0] settle;
  logic                v1;
  logic                accept;
  logic                out_load;
  logic                cfg_wr;
  stride_t             dstr [NDIM];
  coord_t              snap [PACKED_DIMS];
  logic                snap_last;
  logic [OUT_W-1:0]    src_offset;
  logic [OUT_W-1:0]    dst_offset;
  logic [OUT_W-1:0]    element_bytes;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_count <= dim_cnt_t'(1);
      cfg.dim_sizes <= 64'h0001_0001_0001_0001;
      cfg.perm_map  <= 8'hE4;
      cfg.src_low   <= 64'd1;
      cfg.src_high  <= '0;
      cfg.dst_low   <= '0;
      cfg.dst_high  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_DIM_COUNT: cfg.dim_count <= cfg_data[CNT_W-1:0];
        REG_DIM_SIZES: cfg.dim_sizes <= cfg_data;
        REG_PERM_MAP:  cfg.perm_map  <= cfg_data[7:0];
        REG_SRC_LOW:   cfg.src_low   <= cfg_data;
        REG_SRC_HIGH:  cfg.src_high  <= cfg_data;
        REG_DST_LOW:   cfg.dst_low   <= cfg_data;
        REG_DST_HIGH:  cfg.dst_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off items while the dense stride chain settles
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      settle <= SETTLE_W'(NDIM - 1);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // Pipeline flow control: snapshot stage, then result register
  assign out_load = v1 && (!m_tvalid || m_tready);
  assign s_tready = (settle == '0) && (!v1 || out_load);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1       <= accept || (v1 && !out_load);
      m_tvalid <= out_load || (m_tvalid && !m_tready);
    end
  end

  tpag_stride_derive #(.NDIM(NDIM)) u_stride (
    .clk  (clk),
    .cfg  (cfg),
    .dstr (dstr)
  );

  tpag_odometer #(.NDIM(NDIM)) u_odo (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (accept),
    .restart   (s_tdata[0]),
    .snap      (snap),
    .snap_last (snap_last)
  );

  tpag_offset_calc #(.NDIM(NDIM), .OFFSET_BITS(OFFSET_BITS)) u_calc (
    .clk           (clk),
    .load          (out_load),
    .cfg           (cfg),
    .dstr          (dstr),
    .snap          (snap),
    .snap_last     (snap_last),
    .src_offset    (src_offset),
    .dst_offset    (dst_offset),
    .element_bytes (element_bytes),
    .last          (m_tlast)
  );

  assign m_tdata = {element_bytes, dst_offset, src_offset};

endmodule
